// ===== design/response_delay_averager_defines.svh =====
// ----------------------------------------------------------------------------
// Response delay averager assertion macros
// Concurrent check helpers shared by the RTL; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef RESPONSE_DELAY_AVERAGER_DEFINES_SVH
`define RESPONSE_DELAY_AVERAGER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define RDA_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RDA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define RDA_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define RDA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== design/rda_pkg.sv =====
// ----------------------------------------------------------------------------
// Response delay averager package
// Channel payload types, command codes, sequencer states and divider control.
// ----------------------------------------------------------------------------
`default_nettype none

package rda_pkg;

   // command codes
   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   // input item
   typedef struct packed {
      logic        cmd;
      logic [31:0] delay_value;
   } req_type;

   // result item
   typedef struct packed {
      logic [31:0] mean_delay;
      logic [31:0] max_delay;
      logic [8:0]  samples_counted;
   } rsp_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUB,
      ST_ADD,
      ST_DIV,
      ST_QUOT,
      ST_ROUND,
      ST_EMIT
   } state_type;

   // divider control
   typedef struct packed {
      logic init;
      logic step;
   } div_ctl_type;

endpackage

`default_nettype wire

// ===== design/rda_div_serial.sv =====
// ----------------------------------------------------------------------------
// Bit-serial restoring divider
// Takes the dividend one bit per step, MSB first, against a narrow divisor;
// the quotient saturates at the all-ones DELAY_BITS value.
// ----------------------------------------------------------------------------
`default_nettype none

module rda_div_serial #(
   parameter int DELAY_BITS  = 32,
   parameter int WINDOW_LOG2 = 8
) (
   input  wire logic                        clock,
   input  wire rda_pkg::div_ctl_type        ctl,
   input  wire logic                        dividend_bit,
   input  wire logic [WINDOW_LOG2:0]        divisor,
   output logic      [DELAY_BITS-1:0]       quotient
);

   localparam int TW = WINDOW_LOG2 + 1;

   logic [TW-1:0]         rem_ff, rem_in;
   logic [DELAY_BITS-1:0] quo_ff, quo_in;
   logic                  ovf_ff, ovf_in;

   logic [TW:0] trial;
   logic [TW:0] dvs;
   logic [TW:0] diff;
   logic        ge;

   // one quotient bit per step
   always_comb begin
      trial = {rem_ff, dividend_bit};
      dvs   = {1'b0, divisor};
      diff  = trial - dvs;
      ge    = (trial >= dvs);
      rem_in = rem_ff;
      quo_in = quo_ff;
      ovf_in = ovf_ff;
      if (ctl.init) begin
         rem_in = '0;
         quo_in = '0;
         ovf_in = 1'b0;
      end else if (ctl.step) begin
         rem_in = ge ? diff[TW-1:0] : trial[TW-1:0];
         quo_in = {quo_ff[DELAY_BITS-2:0], ge};
         ovf_in = ovf_ff | quo_ff[DELAY_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   // saturate when quotient bits above DELAY_BITS were set
   assign quotient = ovf_ff ? '1 : quo_ff;

endmodule

`default_nettype wire

// ===== design/response_delay_averager.sv =====
// ----------------------------------------------------------------------------
// Response delay averager
// Exact mean over a warm-up window, then an exponential average; tracks max.
// ----------------------------------------------------------------------------
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    rda_pkg::req_type (cmd, delay_value)
//   rsp      out        rsp_valid/stall    rda_pkg::rsp_type (mean, max, count)
//
// A sample item runs the sum through a one-bit serial adder (a subtract pass
// once the window is full, then an add pass) and, in warm-up, a one-bit serial
// divider. A clear zeroes the statistics and goes straight to the result step.
// Reset is synchronous and zeroes the statistics at once.
// A result held by rsp_stall keeps the block in its last step; req waits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "response_delay_averager_defines.svh"

module response_delay_averager #(
   parameter int DELAY_BITS  = 32,
   parameter int WINDOW_LOG2 = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire rda_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rda_pkg::rsp_type       rsp_data
);

   localparam int SW = DELAY_BITS + WINDOW_LOG2;
   localparam int TW = WINDOW_LOG2 + 1;
   localparam int CW = $clog2(SW);
   localparam logic [CW-1:0] DB_CNT   = CW'(DELAY_BITS);
   localparam logic [CW-1:0] LAST_CNT = CW'(SW - 1);
   localparam logic [TW-1:0] WIN      = {1'b1, {WINDOW_LOG2{1'b0}}};

   rda_pkg::state_type    state_ff, state_in;
   logic [SW-1:0]         sum_ff, sum_in;
   logic [TW-1:0]         tally_ff, tally_in;
   logic [DELAY_BITS-1:0] avg_ff, avg_in;
   logic [DELAY_BITS-1:0] peak_ff, peak_in;
   logic [DELAY_BITS-1:0] dly_ff, dly_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  cy_ff, cy_in;
   logic                  gt_ff, gt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rda_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   rda_pkg::div_ctl_type  div_ctl;
   logic [DELAY_BITS-1:0] div_quo;

   logic                  in_range;
   logic                  last;
   logic                  opa, opb;
   logic                  dig;
   logic                  cy_next;
   logic [DELAY_BITS-1:0] hi;
   logic                  rnd;

   rda_div_serial #(
      .DELAY_BITS (DELAY_BITS),
      .WINDOW_LOG2(WINDOW_LOG2)
   ) u_div (
      .clock       (clock),
      .ctl         (div_ctl),
      .dividend_bit(sum_ff[SW-1]),
      .divisor     (tally_ff),
      .quotient    (div_quo)
   );

   // sequencer: next state and datapath
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      tally_in     = tally_ff;
      avg_in       = avg_ff;
      peak_in      = peak_ff;
      dly_in       = dly_ff;
      cnt_in       = cnt_ff;
      cy_in        = cy_ff;
      gt_in        = gt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_ctl      = '0;
      req_stall    = (state_ff != rda_pkg::ST_IDLE);

      in_range = (cnt_ff < DB_CNT);
      last     = (cnt_ff == LAST_CNT);
      opa      = sum_ff[0];
      opb      = 1'b0;
      dig      = 1'b0;
      cy_next  = 1'b0;
      hi       = sum_ff[SW-1:WINDOW_LOG2];
      rnd      = sum_ff[WINDOW_LOG2-1];

      case (state_ff)
         rda_pkg::ST_IDLE: begin
            if (req_valid) begin
               dly_in = req_data.delay_value[DELAY_BITS-1:0];
               cnt_in = '0;
               cy_in  = 1'b0;
               gt_in  = 1'b0;
               if (req_data.cmd == rda_pkg::CMD_CLEAR) begin
                  sum_in   = '0;
                  tally_in = '0;
                  avg_in   = '0;
                  peak_in  = '0;
                  state_in = rda_pkg::ST_EMIT;
               end else if (tally_ff == WIN) begin
                  state_in = rda_pkg::ST_SUB;
               end else begin
                  div_ctl.init = 1'b1;
                  state_in     = rda_pkg::ST_ADD;
               end
            end
         end

         // serial sum - mean, LSB first, floor at zero
         rda_pkg::ST_SUB: begin
            opb     = in_range ? avg_ff[0] : 1'b0;
            dig     = opa ^ opb ^ cy_ff;
            cy_next = (~opa & opb) | (~(opa ^ opb) & cy_ff);
            sum_in  = {dig, sum_ff[SW-1:1]};
            cy_in   = cy_next;
            cnt_in  = cnt_ff + CW'(1);
            if (in_range) begin
               avg_in = {avg_ff[0], avg_ff[DELAY_BITS-1:1]};
            end
            if (last) begin
               if (cy_next) begin
                  sum_in = '0;
               end
               cy_in    = 1'b0;
               cnt_in   = '0;
               state_in = rda_pkg::ST_ADD;
            end
         end

         // serial sum + sample with ceiling; peak compare alongside
         rda_pkg::ST_ADD: begin
            opb     = in_range ? dly_ff[0] : 1'b0;
            dig     = opa ^ opb ^ cy_ff;
            cy_next = (opa & opb) | (cy_ff & (opa ^ opb));
            sum_in  = {dig, sum_ff[SW-1:1]};
            cy_in   = cy_next;
            cnt_in  = cnt_ff + CW'(1);
            if (in_range) begin
               gt_in   = (dly_ff[0] & ~peak_ff[0]) | (~(dly_ff[0] ^ peak_ff[0]) & gt_ff);
               dly_in  = {dly_ff[0], dly_ff[DELAY_BITS-1:1]};
               peak_in = {peak_ff[0], peak_ff[DELAY_BITS-1:1]};
            end
            if (last) begin
               if (cy_next) begin
                  sum_in = '1;
               end
               if (gt_ff) begin
                  peak_in = dly_ff;
               end
               // warm-up count grows here, so the last warm-up sample still divides
               if (tally_ff != WIN) begin
                  tally_in = tally_ff + TW'(1);
               end
               cy_in    = 1'b0;
               cnt_in   = '0;
               state_in = (tally_ff == WIN) ? rda_pkg::ST_ROUND : rda_pkg::ST_DIV;
            end
         end

         // warm-up mean: sum rotates left into the divider
         rda_pkg::ST_DIV: begin
            div_ctl.step = 1'b1;
            sum_in       = {sum_ff[SW-2:0], sum_ff[SW-1]};
            cnt_in       = cnt_ff + CW'(1);
            if (last) begin
               cnt_in   = '0;
               state_in = rda_pkg::ST_QUOT;
            end
         end

         rda_pkg::ST_QUOT: begin
            avg_in   = div_quo;
            state_in = rda_pkg::ST_EMIT;
         end

         // rounded shift, saturating at all ones
         rda_pkg::ST_ROUND: begin
            avg_in   = (rnd && !(&hi)) ? hi + DELAY_BITS'(1) : hi;
            state_in = rda_pkg::ST_EMIT;
         end

         rda_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.mean_delay      = 32'(avg_ff);
               rsp_data_in.max_delay       = 32'(peak_ff);
               rsp_data_in.samples_counted = 9'(tally_ff);
               rsp_valid_in                = 1'b1;
               state_in                    = rda_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = rda_pkg::ST_IDLE;
         end
      endcase
   end

   // control and statistics registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rda_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         tally_ff     <= '0;
         avg_ff       <= '0;
         peak_ff      <= '0;
         cnt_ff       <= '0;
         cy_ff        <= 1'b0;
         gt_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         tally_ff     <= tally_in;
         avg_ff       <= avg_in;
         peak_ff      <= peak_in;
         cnt_ff       <= cnt_in;
         cy_ff        <= cy_in;
         gt_ff        <= gt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dly_ff      <= dly_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `RDA_ASSERT_NEXT(a_busy_after_transfer, clock, reset,
      req_valid && !req_stall, req_stall, "request transfer did not start a sequence")
   `RDA_ASSERT_IMPLY(a_div_nonzero, clock, reset,
      state_ff == rda_pkg::ST_DIV, tally_ff != '0, "divide with zero tally")
   `RDA_ASSERT_IMPLY(a_round_full, clock, reset,
      state_ff == rda_pkg::ST_ROUND, tally_ff == WIN, "exponential update before window is full")
   `RDA_ASSERT_NEXT(a_emit_hold, clock, reset,
      state_ff == rda_pkg::ST_EMIT && rsp_valid && rsp_stall, state_ff == rda_pkg::ST_EMIT,
      "result emitted over a stalled transfer")

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Response delay averager testbench
// Feeds add and clear items with random gaps, predicts mean, max and count
// per item, and compares every result transfer against the prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   // window and saturation bounds of the default configuration
   localparam int          WINDOW_LOG2 = 8;
   localparam logic [8:0]  WINDOW_FULL = 9'd256;
   localparam logic [40:0] SUM_LIMIT   = 41'h0FF_FFFF_FFFF;
   localparam logic [40:0] DELAY_LIMIT = 41'h000_FFFF_FFFF;
   localparam logic [7:0]  ROUND_HALF  = 8'd128;
   localparam int          NUM_RANDOM  = 1500;
   localparam int          HOLD_CYCLES = 600;
   // worst case: 1516 items, each with the longest sequence, gap and stall, plus the hold
   localparam int          CYCLE_LIMIT = 2000000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   rda_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rda_pkg::rsp_type rsp_data;

   // predicted block state
   logic [39:0] stat_sum   = '0;
   logic [8:0]  stat_count = '0;
   logic [31:0] stat_mean  = '0;
   logic [31:0] stat_peak  = '0;

   rda_pkg::req_type pending_items[$];
   rda_pkg::rsp_type expected_stats[$];
   rda_pkg::rsp_type stats_want;

   int cycle_count  = 0;
   int error_count  = 0;
   int results_seen = 0;
   int gap_left     = 0;
   int stall_left   = 0;
   bit hold_done    = 1'b0;

   // some stretches run with no idling on either side
   wire calm = (cycle_count[11:10] == 2'b11);

   response_delay_averager uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // apply one item to the predicted state, return the expected result
   function automatic rda_pkg::rsp_type advance_delay_stats(rda_pkg::req_type item);
      logic [40:0]      wide_sum;
      logic [40:0]      mean_calc;
      rda_pkg::rsp_type res;
      if (item.cmd == rda_pkg::CMD_CLEAR) begin
         stat_sum   = '0;
         stat_count = '0;
         stat_mean  = '0;
         stat_peak  = '0;
      end else if (stat_count >= WINDOW_FULL) begin
         // exponential phase: drop the mean, add the sample, round
         stat_count = WINDOW_FULL;
         wide_sum = (stat_mean > stat_sum) ? 41'd0 : {1'b0, stat_sum} - stat_mean;
         wide_sum = wide_sum + item.delay_value;
         if (wide_sum > SUM_LIMIT)
            wide_sum = SUM_LIMIT;
         stat_sum  = wide_sum[39:0];
         mean_calc = wide_sum >> WINDOW_LOG2;
         if (wide_sum[7:0] >= ROUND_HALF)
            mean_calc = mean_calc + 41'd1;
         stat_mean = (mean_calc > DELAY_LIMIT) ? DELAY_LIMIT[31:0] : mean_calc[31:0];
      end else begin
         // warm-up: exact sum over exact count, truncated
         stat_count = stat_count + 9'd1;
         wide_sum = {1'b0, stat_sum} + item.delay_value;
         if (wide_sum > SUM_LIMIT)
            wide_sum = SUM_LIMIT;
         stat_sum  = wide_sum[39:0];
         mean_calc = wide_sum / {32'd0, stat_count};
         stat_mean = (mean_calc > DELAY_LIMIT) ? DELAY_LIMIT[31:0] : mean_calc[31:0];
      end
      if (item.cmd == rda_pkg::CMD_ADD && item.delay_value > stat_peak)
         stat_peak = item.delay_value;
      res.mean_delay      = stat_mean;
      res.max_delay       = stat_peak;
      res.samples_counted = stat_count;
      return res;
   endfunction

   // delay values spread over small, mid, full-range, single-bit and near-max classes
   function automatic logic [31:0] draw_delay();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5:       return $urandom_range(0, 255);
         6:          return 32'hFFFF_FFFF - $urandom_range(0, 15);
         7:          return 32'd1 << $urandom_range(0, 31);
         default:    return $urandom_range(0, 65535);
      endcase
   endfunction

   function automatic int draw_send_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else if (roll < 98)
         return $urandom_range(4, 20);
      else
         return $urandom_range(30, 150);
   endfunction

   function automatic int draw_stall_len();
      if ($urandom_range(0, 19) == 0)
         return $urandom_range(15, 60);
      else
         return $urandom_range(0, 3);
   endfunction

   function automatic rda_pkg::req_type make_item(logic cmd, logic [31:0] delay);
      rda_pkg::req_type item;
      item.cmd         = cmd;
      item.delay_value = delay;
      return item;
   endfunction

   // driver: offers the next pending item, predicts each accepted transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_stats.push_back(advance_delay_stats(req_data));
         if (!req_valid || !req_stall) begin
            if (gap_left != 0 || pending_items.size() == 0) begin
               req_valid <= 1'b0;
               if (gap_left != 0)
                  gap_left <= gap_left - 1;
            end else begin
               req_valid <= 1'b1;
               req_data  <= pending_items.pop_front();
               gap_left  <= draw_send_gap();
            end
         end
      end
   end

   // monitor: checks each result transfer and paces rsp_stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_stats.size() == 0) begin
               $error("result with no pending prediction: mean %0d max %0d count %0d",
                      rsp_data.mean_delay, rsp_data.max_delay, rsp_data.samples_counted);
               error_count++;
            end else begin
               stats_want = expected_stats.pop_front();
               if (rsp_data.mean_delay !== stats_want.mean_delay) begin
                  $error("mean_delay: expected %0d, actual %0d",
                         stats_want.mean_delay, rsp_data.mean_delay);
                  error_count++;
               end
               if (rsp_data.max_delay !== stats_want.max_delay) begin
                  $error("max_delay: expected %0d, actual %0d",
                         stats_want.max_delay, rsp_data.max_delay);
                  error_count++;
               end
               if (rsp_data.samples_counted !== stats_want.samples_counted) begin
                  $error("samples_counted: expected %0d, actual %0d",
                         stats_want.samples_counted, rsp_data.samples_counted);
                  error_count++;
               end
            end
         end
         // one long hold-off so the block backs up into req_stall
         if (results_seen == 120 && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall  <= 1'b1;
            stall_left <= HOLD_CYCLES;
         end else if (stall_left != 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (!calm && $urandom_range(0, 99) < 12) begin
            rsp_stall  <= 1'b1;
            stall_left <= draw_stall_len();
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      // directed: clears, field extremes, bit patterns, truncation
      pending_items.push_back(make_item(rda_pkg::CMD_CLEAR, 32'h0000_0000));
      pending_items.push_back(make_item(rda_pkg::CMD_ADD,   32'h0000_0000));
      pending_items.push_back(make_item(rda_pkg::CMD_ADD,   32'hFFFF_FFFF));
      pending_items.push_back(make_item(rda_pkg::CMD_ADD,   32'h0000_0001));
      pending_items.push_back(make_item(rda_pkg::CMD_ADD,   32'h8000_0000));
      pending_items.push_back(make_item(rda_pkg::CMD_ADD,   32'h7FFF_FFFF));
      pending_items.push_back(make_item(rda_pkg::CMD_ADD,   32'hAAAA_AAAA));
      pending_items.push_back(make_item(rda_pkg::CMD_ADD,   32'h5555_5555));
      pending_items.push_back(make_item(rda_pkg::CMD_CLEAR, 32'hFFFF_FFFF));
      pending_items.push_back(make_item(rda_pkg::CMD_ADD,   32'h0000_0003));
      pending_items.push_back(make_item(rda_pkg::CMD_ADD,   32'h0000_0002));
      pending_items.push_back(make_item(rda_pkg::CMD_ADD,   32'h0000_0000));
      pending_items.push_back(make_item(rda_pkg::CMD_CLEAR, 32'h0000_0000));
      pending_items.push_back(make_item(rda_pkg::CMD_ADD,   32'hFFFF_FFFF));
      pending_items.push_back(make_item(rda_pkg::CMD_ADD,   32'hFFFF_FFFF));
      pending_items.push_back(make_item(rda_pkg::CMD_ADD,   32'hFFFF_0000));
      // random: long runs past warm-up, one full-scale window, then decay
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n == 500)
            pending_items.push_back(make_item(rda_pkg::CMD_CLEAR, $urandom));
         else if (n > 500 && n < 800)
            pending_items.push_back(make_item(rda_pkg::CMD_ADD, 32'hFFFF_FFFF));
         else if (n >= 800 && n < 900)
            pending_items.push_back(make_item(rda_pkg::CMD_ADD, $urandom_range(0, 3)));
         else if ($urandom_range(0, 399) == 0)
            pending_items.push_back(make_item(rda_pkg::CMD_CLEAR, $urandom));
         else
            pending_items.push_back(make_item(rda_pkg::CMD_ADD, draw_delay()));
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_valid || expected_stats.size() != 0)
         @(posedge clock);
      // give room for a stray result
      repeat (200) @(posedge clock);

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
